@@ hdl/tcc_pkg.sv @@
// Shared constants and helper functions for the triangle circumcircle unit.
`default_nettype none
package tcc_pkg;

  localparam int CoordWidthDef = 32;
  localparam int FracBitsDef   = 16;

  // Width of the circle-equation constant: coordinate plus fraction bits, capped at 64.
  function automatic int tcc_eq_width(input int coord_w, input int frac_w);
    int sum_w;
    sum_w = coord_w + frac_w;
    return (sum_w < 64) ? sum_w : 64;
  endfunction

endpackage
`default_nettype wire

@@ hdl/tcc_div_pipe.sv @@
// Pipelined restoring divider, one quotient bit per register stage.
`default_nettype none
module tcc_div_pipe #(
  parameter int NUM_W  = 100,
  parameter int DEN_W  = 68,
  parameter int QUO_W  = 34,
  parameter int SIDE_W = 1
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              en,
  input  wire logic              in_valid,
  input  wire logic [NUM_W-1:0]  in_num,
  input  wire logic [DEN_W-1:0]  in_den,
  input  wire logic [SIDE_W-1:0] in_side,
  output logic                   out_valid,
  output logic [QUO_W-1:0]       out_quo,
  output logic [SIDE_W-1:0]      out_side
);

  // The caller guarantees in_num < in_den * 2**QUO_W whenever the quotient is used.
  logic              valid_r [QUO_W];
  logic [DEN_W-1:0]  rem_r   [QUO_W];
  logic [DEN_W-1:0]  den_r   [QUO_W];
  logic [QUO_W-1:0]  low_r   [QUO_W];
  logic [QUO_W-1:0]  quo_r   [QUO_W];
  logic [SIDE_W-1:0] side_r  [QUO_W];

  for (genvar i = 0; i < QUO_W; i++) begin : g_stage
    logic              vld_in;
    logic [DEN_W-1:0]  rem_in;
    logic [DEN_W-1:0]  den_in;
    logic [QUO_W-1:0]  low_in;
    logic [QUO_W-1:0]  quo_in;
    logic [SIDE_W-1:0] side_in;
    logic [DEN_W:0]    trial;
    logic [DEN_W:0]    diff;
    logic              ge;

    if (i == 0) begin : g_first
      assign vld_in  = in_valid;
      assign rem_in  = DEN_W'(in_num[NUM_W-1:QUO_W]);
      assign den_in  = in_den;
      assign low_in  = in_num[QUO_W-1:0];
      assign quo_in  = '0;
      assign side_in = in_side;
    end else begin : g_next
      assign vld_in  = valid_r[i-1];
      assign rem_in  = rem_r[i-1];
      assign den_in  = den_r[i-1];
      assign low_in  = low_r[i-1];
      assign quo_in  = quo_r[i-1];
      assign side_in = side_r[i-1];
    end

    assign trial = {rem_in, low_in[QUO_W-1]};
    assign diff  = trial - {1'b0, den_in};
    assign ge    = (trial >= {1'b0, den_in});

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[i] <= 1'b0;
      end else if (en) begin
        valid_r[i] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i]  <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        den_r[i]  <= den_in;
        low_r[i]  <= low_in << 1;
        quo_r[i]  <= {quo_in[QUO_W-2:0], ge};
        side_r[i] <= side_in;
      end
    end
  end

  assign out_valid = valid_r[QUO_W-1];
  assign out_quo   = quo_r[QUO_W-1];
  assign out_side  = side_r[QUO_W-1];

endmodule
`default_nettype wire

@@ hdl/tcc_sqrt_pipe.sv @@
// Pipelined integer square root, one root bit per register stage, with final remainder.
`default_nettype none
module tcc_sqrt_pipe #(
  parameter int RES_W  = 32,
  parameter int SIDE_W = 1
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               en,
  input  wire logic               in_valid,
  input  wire logic [2*RES_W-1:0] in_rad,
  input  wire logic [SIDE_W-1:0]  in_side,
  output logic                    out_valid,
  output logic [RES_W-1:0]        out_root,
  output logic [RES_W:0]          out_rem,
  output logic [SIDE_W-1:0]       out_side
);

  localparam int AW = 2 * RES_W;

  logic              valid_r [RES_W];
  logic [AW-1:0]     rem_r   [RES_W];
  logic [AW-1:0]     root_r  [RES_W];
  logic [SIDE_W-1:0] side_r  [RES_W];

  for (genvar i = 0; i < RES_W; i++) begin : g_stage
    localparam logic [AW-1:0] Bit = AW'(1) << (2 * (RES_W - 1 - i));
    logic              vld_in;
    logic [AW-1:0]     rem_in;
    logic [AW-1:0]     root_in;
    logic [SIDE_W-1:0] side_in;
    logic [AW-1:0]     trial;
    logic              ge;

    if (i == 0) begin : g_first
      assign vld_in  = in_valid;
      assign rem_in  = in_rad;
      assign root_in = '0;
      assign side_in = in_side;
    end else begin : g_next
      assign vld_in  = valid_r[i-1];
      assign rem_in  = rem_r[i-1];
      assign root_in = root_r[i-1];
      assign side_in = side_r[i-1];
    end

    assign trial = root_in + Bit;
    assign ge    = (rem_in >= trial);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[i] <= 1'b0;
      end else if (en) begin
        valid_r[i] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i]  <= ge ? (rem_in - trial) : rem_in;
        root_r[i] <= ge ? ((root_in >> 1) + Bit) : (root_in >> 1);
        side_r[i] <= side_in;
      end
    end
  end

  // After the last step the root holds floor(sqrt) and the remainder is at most twice it.
  assign out_valid = valid_r[RES_W-1];
  assign out_root  = root_r[RES_W-1][RES_W-1:0];
  assign out_rem   = rem_r[RES_W-1][RES_W:0];
  assign out_side  = side_r[RES_W-1];

endmodule
`default_nettype wire

@@ hdl/triangle_circumcircle_unit.sv @@
// Triangle circumcircle unit: circumcenter, circumradius and circle-equation constant.
//
// Usage: a request on the input channel carries the three vertices of a triangle in
// signed fixed point. Each request yields exactly one result request on the output
// channel, in order. Both channels use valid/stall: a request moves at a rising edge
// where valid is high and stall is low.
// The pipeline takes one triangle every cycle while the receiver does not stall; its
// length is set by the two long dividers (COORD_WIDTH+2 stages, one quotient bit
// each) and the square root (COORD_WIDTH stages, one root bit each).
// The whole pipeline moves on one shared enable. When the output register holds a
// result that the receiver stalls, every stage holds and in_stall rises in the same
// cycle; nothing is dropped or repeated. A result that is taken frees the output
// register, so a new request enters in that same cycle.
// Reset (synchronous, active low) clears all valid bits; the unit is ready at once.
// Collinear points give degenerate=1 with all other results zero.
`default_nettype none
module triangle_circumcircle_unit
  import tcc_pkg::*;
#(
  parameter int COORD_WIDTH = CoordWidthDef,
  parameter int FRAC_BITS   = FracBitsDef
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic signed [COORD_WIDTH-1:0] in_first_x,
  input  wire logic signed [COORD_WIDTH-1:0] in_first_y,
  input  wire logic signed [COORD_WIDTH-1:0] in_second_x,
  input  wire logic signed [COORD_WIDTH-1:0] in_second_y,
  input  wire logic signed [COORD_WIDTH-1:0] in_third_x,
  input  wire logic signed [COORD_WIDTH-1:0] in_third_y,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic signed [COORD_WIDTH-1:0]      out_center_x,
  output logic signed [COORD_WIDTH-1:0]      out_center_y,
  output logic [COORD_WIDTH-2:0]             out_radius,
  output logic signed [tcc_eq_width(COORD_WIDTH, FRAC_BITS)-1:0] out_equation_constant,
  output logic                               out_degenerate,
  output logic                               out_overflowed
);

  localparam int W    = COORD_WIDTH;
  localparam int F    = FRAC_BITS;
  localparam int DW   = W + 1;          // edge vector components
  localparam int PW   = 2 * W + 2;      // edge component times edge component
  localparam int CRW  = 2 * W + 3;      // cross product
  localparam int NBW  = 2 * W + 2;      // squared edge lengths, unsigned
  localparam int HW   = W + 1;          // half of a squared length, for split products
  localparam int PPW  = 2 * W + 3;      // partial product
  localparam int XW   = 3 * W + 4;      // perp numerator and dividend
  localparam int DVW  = 2 * W + 4;      // divisor, twice the absolute cross product
  localparam int QW   = W + 2;          // quotient magnitude bits
  localparam int CMPW = 3 * W + 6;
  localparam int RW   = W - 1;          // radius
  localparam int EQW  = tcc_eq_width(W, F);
  localparam int KW   = 3 * W + F + 2;  // constant term before rounding
  localparam int XSW  = 3 + 2 * W;
  localparam int SSW  = 3 + 2 * W;

  localparam logic signed [W+3:0] PosMax = $signed({5'b00000, {(W-1){1'b1}}});
  localparam logic signed [W+3:0] PosMin = $signed({5'b11111, {(W-1){1'b0}}});
  localparam logic [W:0]          RadMax = {2'b00, {(W-1){1'b1}}};
  localparam logic signed [KW-1:0] KHalf = $signed({{(KW-F){1'b0}}, 1'b1, {(F-1){1'b0}}});
  localparam logic signed [KW-1:0] EqMax = $signed({{(KW-EQW+1){1'b0}}, {(EQW-1){1'b1}}});
  localparam logic signed [KW-1:0] EqMin = $signed({{(KW-EQW+1){1'b1}}, {(EQW-1){1'b0}}});

  // One enable moves every stage; it drops only when a finished result is held.
  logic en;
  assign en       = !out_valid || !out_stall;
  assign in_stall = !en;

  // Stage 1: edge vectors from the first vertex.
  logic                 v1_r;
  logic signed [W-1:0]  ax1_r, ay1_r;
  logic signed [DW-1:0] bx1_r, by1_r, cx1_r, cy1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ax1_r <= in_first_x;
      ay1_r <= in_first_y;
      bx1_r <= DW'(in_second_x) - DW'(in_first_x);
      by1_r <= DW'(in_second_y) - DW'(in_first_y);
      cx1_r <= DW'(in_third_x) - DW'(in_first_x);
      cy1_r <= DW'(in_third_y) - DW'(in_first_y);
    end
  end

  // Stage 2: squares and the two cross-product terms.
  logic                 v2_r;
  logic signed [W-1:0]  ax2_r, ay2_r;
  logic signed [DW-1:0] bx2_r, by2_r, cx2_r, cy2_r;
  logic signed [PW-1:0] sbx2_r, sby2_r, scx2_r, scy2_r, mbc2_r, mcb2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ax2_r  <= ax1_r;
      ay2_r  <= ay1_r;
      bx2_r  <= bx1_r;
      by2_r  <= by1_r;
      cx2_r  <= cx1_r;
      cy2_r  <= cy1_r;
      sbx2_r <= bx1_r * bx1_r;
      sby2_r <= by1_r * by1_r;
      scx2_r <= cx1_r * cx1_r;
      scy2_r <= cy1_r * cy1_r;
      mbc2_r <= bx1_r * cy1_r;
      mcb2_r <= by1_r * cx1_r;
    end
  end

  // Stage 3: squared edge lengths and the cross product.
  logic                  v3_r;
  logic signed [W-1:0]   ax3_r, ay3_r;
  logic signed [DW-1:0]  bx3_r, by3_r, cx3_r, cy3_r;
  logic [NBW-1:0]        nb3_r, nc3_r;
  logic signed [CRW-1:0] cr3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ax3_r <= ax2_r;
      ay3_r <= ay2_r;
      bx3_r <= bx2_r;
      by3_r <= by2_r;
      cx3_r <= cx2_r;
      cy3_r <= cy2_r;
      nb3_r <= $unsigned(sbx2_r) + $unsigned(sby2_r);
      nc3_r <= $unsigned(scx2_r) + $unsigned(scy2_r);
      cr3_r <= CRW'(mbc2_r) - CRW'(mcb2_r);
    end
  end

  // Stage 4: the wide products edge * length are split into two halves of the length.
  logic                  v4_r;
  logic signed [W-1:0]   ax4_r, ay4_r;
  logic signed [CRW-1:0] cr4_r;
  logic signed [PPW-1:0] pbl4_r, pbh4_r, pcl4_r, pch4_r;
  logic signed [PPW-1:0] qbl4_r, qbh4_r, qcl4_r, qch4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (en) begin
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ax4_r  <= ax3_r;
      ay4_r  <= ay3_r;
      cr4_r  <= cr3_r;
      pbl4_r <= bx3_r * $signed({1'b0, nc3_r[HW-1:0]});
      pbh4_r <= bx3_r * $signed({1'b0, nc3_r[NBW-1:HW]});
      pcl4_r <= cx3_r * $signed({1'b0, nb3_r[HW-1:0]});
      pch4_r <= cx3_r * $signed({1'b0, nb3_r[NBW-1:HW]});
      qbl4_r <= by3_r * $signed({1'b0, nc3_r[HW-1:0]});
      qbh4_r <= by3_r * $signed({1'b0, nc3_r[NBW-1:HW]});
      qcl4_r <= cy3_r * $signed({1'b0, nb3_r[HW-1:0]});
      qch4_r <= cy3_r * $signed({1'b0, nb3_r[NBW-1:HW]});
    end
  end

  // Stage 5: numerator b*|c|^2 - c*|b|^2 and the collinear check.
  logic                  v5_r;
  logic signed [W-1:0]   ax5_r, ay5_r;
  logic signed [CRW-1:0] cr5_r;
  logic signed [XW-1:0]  nx5_r, ny5_r;
  logic                  deg5_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else if (en) begin
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ax5_r  <= ax4_r;
      ay5_r  <= ay4_r;
      cr5_r  <= cr4_r;
      deg5_r <= (cr4_r == '0);
      nx5_r  <= (XW'(pbh4_r) <<< HW) + XW'(pbl4_r) - (XW'(pch4_r) <<< HW) - XW'(pcl4_r);
      ny5_r  <= (XW'(qbh4_r) <<< HW) + XW'(qbl4_r) - (XW'(qch4_r) <<< HW) - XW'(qcl4_r);
    end
  end

  // Stage 6: sign-magnitude form for rounding division, halves away from zero:
  // |offset| = (|num| + |cr|) / (2|cr|). The x offset uses -ny, the y offset nx.
  logic [XW-1:0]  abs_nx_c, abs_ny_c;
  logic [CRW-1:0] abs_cr_c;
  logic [DVW-1:0] den_c;
  logic [XW-1:0]  num_x_c, num_y_c;

  always_comb begin
    abs_nx_c = nx5_r[XW-1] ? $unsigned(-nx5_r) : $unsigned(nx5_r);
    abs_ny_c = ny5_r[XW-1] ? $unsigned(-ny5_r) : $unsigned(ny5_r);
    abs_cr_c = cr5_r[CRW-1] ? $unsigned(-cr5_r) : $unsigned(cr5_r);
    den_c    = {abs_cr_c, 1'b0};
    num_x_c  = abs_ny_c + XW'(abs_cr_c);
    num_y_c  = abs_nx_c + XW'(abs_cr_c);
  end

  logic                 v6_r;
  logic signed [W-1:0]  ax6_r, ay6_r;
  logic [XW-1:0]        num_x6_r, num_y6_r;
  logic [DVW-1:0]       den6_r;
  logic                 hx6_r, hy6_r, sx6_r, sy6_r, deg6_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v6_r <= 1'b0;
    end else if (en) begin
      v6_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ax6_r    <= ax5_r;
      ay6_r    <= ay5_r;
      deg6_r   <= deg5_r;
      num_x6_r <= num_x_c;
      num_y6_r <= num_y_c;
      den6_r   <= den_c;
      // A quotient past the divider's range saturates the center and the radius that it feeds.
      hx6_r    <= (CMPW'(num_x_c) >= (CMPW'(den_c) << QW));
      hy6_r    <= (CMPW'(num_y_c) >= (CMPW'(den_c) << QW));
      sx6_r    <= (!ny5_r[XW-1] && (ny5_r != '0)) != cr5_r[CRW-1];
      sy6_r    <= nx5_r[XW-1] != cr5_r[CRW-1];
    end
  end

  // Two long dividers run side by side; the x lane carries the rest of the item.
  logic           vx_d, vy_d;
  logic [QW-1:0]  qx_d, qy_d;
  logic [XSW-1:0] xside_d;
  logic [1:0]     yside_d;

  tcc_div_pipe #(
    .NUM_W (XW),
    .DEN_W (DVW),
    .QUO_W (QW),
    .SIDE_W(XSW)
  ) u_div_x (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (v6_r),
    .in_num   (num_x6_r),
    .in_den   (den6_r),
    .in_side  ({sx6_r, hx6_r, deg6_r, ax6_r, ay6_r}),
    .out_valid(vx_d),
    .out_quo  (qx_d),
    .out_side (xside_d)
  );

  tcc_div_pipe #(
    .NUM_W (XW),
    .DEN_W (DVW),
    .QUO_W (QW),
    .SIDE_W(2)
  ) u_div_y (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (v6_r),
    .in_num   (num_y6_r),
    .in_den   (den6_r),
    .in_side  ({sy6_r, hy6_r}),
    .out_valid(vy_d),
    .out_quo  (qy_d),
    .out_side (yside_d)
  );

  // Stage A: signed offsets, saturated center, squared offsets for the radius.
  logic                sx_d, hx_d, deg_d, sy_d, hy_d;
  logic signed [W-1:0] ax_d, ay_d;
  logic [QW-1:0]       magx_c, magy_c;
  logic signed [QW:0]  ox_c, oy_c;
  logic signed [W+3:0] sumx_c, sumy_c;
  logic signed [W-1:0] px_c, py_c;
  logic                ofx_c, ofy_c;

  assign {sx_d, hx_d, deg_d, ax_d, ay_d} = xside_d;
  assign {sy_d, hy_d}                    = yside_d;

  always_comb begin
    magx_c = hx_d ? '1 : qx_d;
    magy_c = hy_d ? '1 : qy_d;
    ox_c   = sx_d ? -$signed({1'b0, magx_c}) : $signed({1'b0, magx_c});
    oy_c   = sy_d ? -$signed({1'b0, magy_c}) : $signed({1'b0, magy_c});
    sumx_c = (W+4)'(ax_d) + (W+4)'(ox_c);
    sumy_c = (W+4)'(ay_d) + (W+4)'(oy_c);
    ofx_c  = (sumx_c > PosMax) || (sumx_c < PosMin);
    ofy_c  = (sumy_c > PosMax) || (sumy_c < PosMin);
    if (sumx_c > PosMax) begin
      px_c = PosMax[W-1:0];
    end else if (sumx_c < PosMin) begin
      px_c = PosMin[W-1:0];
    end else begin
      px_c = sumx_c[W-1:0];
    end
    if (sumy_c > PosMax) begin
      py_c = PosMax[W-1:0];
    end else if (sumy_c < PosMin) begin
      py_c = PosMin[W-1:0];
    end else begin
      py_c = sumy_c[W-1:0];
    end
  end

  logic                va_r;
  logic signed [W-1:0] pxa_r, pya_r;
  logic                ofa_r, rofa_r, dega_r;
  logic [2*W-3:0]      sqxa_r, sqya_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
    end else if (en) begin
      va_r <= vx_d & vy_d;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pxa_r  <= px_c;
      pya_r  <= py_c;
      ofa_r  <= ofx_c | ofy_c;
      // An offset of 2**(W-1) or more in magnitude already saturates the radius.
      rofa_r <= (|magx_c[QW-1:W-1]) | (|magy_c[QW-1:W-1]);
      dega_r <= deg_d;
      sqxa_r <= magx_c[W-2:0] * magx_c[W-2:0];
      sqya_r <= magy_c[W-2:0] * magy_c[W-2:0];
    end
  end

  // Stage B: squared radius.
  logic                vb_r;
  logic signed [W-1:0] pxb_r, pyb_r;
  logic                ofb_r, rofb_r, degb_r;
  logic [2*W-1:0]      sb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb_r <= 1'b0;
    end else if (en) begin
      vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pxb_r  <= pxa_r;
      pyb_r  <= pya_r;
      ofb_r  <= ofa_r;
      rofb_r <= rofa_r;
      degb_r <= dega_r;
      sb_r   <= (2*W)'(sqxa_r) + (2*W)'(sqya_r);
    end
  end

  logic                vs_d;
  logic [W-1:0]        root_d;
  logic [W:0]          rem_d;
  logic [SSW-1:0]      sside_d;
  logic                degs_d, ofs_d, rofs_d;
  logic signed [W-1:0] pxs_d, pys_d;

  tcc_sqrt_pipe #(
    .RES_W (W),
    .SIDE_W(SSW)
  ) u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (vb_r),
    .in_rad   (sb_r),
    .in_side  ({degb_r, ofb_r, rofb_r, pxb_r, pyb_r}),
    .out_valid(vs_d),
    .out_root (root_d),
    .out_rem  (rem_d),
    .out_side (sside_d)
  );

  assign {degs_d, ofs_d, rofs_d, pxs_d, pys_d} = sside_d;

  // Stage C: round the root to nearest and saturate the radius.
  logic [W:0] rnd_c;
  assign rnd_c = (W+1)'(root_d) + (W+1)'(rem_d > (W+1)'(root_d));

  logic                vc_r;
  logic signed [W-1:0] pxc_r, pyc_r;
  logic [RW-1:0]       radc_r;
  logic                ofc_r, degc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r <= 1'b0;
    end else if (en) begin
      vc_r <= vs_d;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pxc_r  <= pxs_d;
      pyc_r  <= pys_d;
      degc_r <= degs_d;
      if (rofs_d || (rnd_c > RadMax)) begin
        radc_r <= RadMax[RW-1:0];
        ofc_r  <= 1'b1;
      end else begin
        radc_r <= rnd_c[RW-1:0];
        ofc_r  <= ofs_d;
      end
    end
  end

  // Stage D: squares for the equation constant.
  logic                  vd_r;
  logic signed [W-1:0]   pxd_r, pyd_r;
  logic [RW-1:0]         radd_r;
  logic                  ofd_r, degd_r;
  logic signed [2*W-1:0] pxxd_r, pyyd_r;
  logic [2*RW-1:0]       rrd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vd_r <= 1'b0;
    end else if (en) begin
      vd_r <= vc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pxd_r  <= pxc_r;
      pyd_r  <= pyc_r;
      radd_r <= radc_r;
      ofd_r  <= ofc_r;
      degd_r <= degc_r;
      pxxd_r <= pxc_r * pxc_r;
      pyyd_r <= pyc_r * pyc_r;
      rrd_r  <= radc_r * radc_r;
    end
  end

  // Stage E (output register): constant rounded half up, then saturated.
  logic signed [KW-1:0] k_c, ks_c;
  logic                 kof_c;
  logic [EQW-1:0]       eq_c;

  always_comb begin
    k_c   = KW'(pxxd_r) + KW'(pyyd_r) - KW'($signed({1'b0, rrd_r})) + KHalf;
    ks_c  = k_c >>> F;
    kof_c = (ks_c > EqMax) || (ks_c < EqMin);
    if (ks_c > EqMax) begin
      eq_c = EqMax[EQW-1:0];
    end else if (ks_c < EqMin) begin
      eq_c = EqMin[EQW-1:0];
    end else begin
      eq_c = ks_c[EQW-1:0];
    end
  end

  logic out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= vd_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (degd_r) begin
        out_center_x          <= '0;
        out_center_y          <= '0;
        out_radius            <= '0;
        out_equation_constant <= '0;
        out_degenerate        <= 1'b1;
        out_overflowed        <= 1'b0;
      end else begin
        out_center_x          <= pxd_r;
        out_center_y          <= pyd_r;
        out_radius            <= radd_r;
        out_equation_constant <= $signed(eq_c);
        out_degenerate        <= 1'b0;
        out_overflowed        <= ofd_r | kof_c;
      end
    end
  end

  assign out_valid = out_valid_r;

endmodule
`default_nettype wire

@@ tb/sv/tb_triangle_circumcircle_unit.sv @@
// Self-checking testbench for the triangle circumcircle unit.
`default_nettype none
module tb_triangle_circumcircle_unit
  import tcc_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CW = CoordWidthDef;
  localparam int FB = FracBitsDef;
  localparam int EW = tcc_eq_width(CoordWidthDef, FracBitsDef);
  // Idle wait after the final drain, longer than the whole pipeline of the unit.
  localparam int DrainCycles = 2 * CW + 13 + 50;

  // All exact arithmetic is done in a wide signed integer; the largest
  // intermediate (an edge vector times a squared length) stays below 2^97.
  typedef logic signed [255:0] wide_t;

  typedef struct {
    logic signed [CW-1:0] ax, ay, bx, by, cx, cy;
  } triangle_t;

  typedef struct {
    logic signed [CW-1:0] px, py;
    logic [CW-2:0]        rad;
    logic signed [EW-1:0] k;
    logic                 degen;
    logic                 ovf;
  } circle_t;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  logic signed [CW-1:0] in_first_x, in_first_y, in_second_x, in_second_y;
  logic signed [CW-1:0] in_third_x, in_third_y;
  logic                 out_valid;
  logic                 out_stall;
  logic signed [CW-1:0] out_center_x, out_center_y;
  logic [CW-2:0]        out_radius;
  logic signed [EW-1:0] out_equation_constant;
  logic                 out_degenerate;
  logic                 out_overflowed;

  circle_t pending_circles[$];
  int      mismatch_count = 0;
  bit      steady_mode = 0;  // when set, neither side idles

  triangle_circumcircle_unit u_dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_first_x            (in_first_x),
    .in_first_y            (in_first_y),
    .in_second_x           (in_second_x),
    .in_second_y           (in_second_y),
    .in_third_x            (in_third_x),
    .in_third_y            (in_third_y),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_center_x          (out_center_x),
    .out_center_y          (out_center_y),
    .out_radius            (out_radius),
    .out_equation_constant (out_equation_constant),
    .out_degenerate        (out_degenerate),
    .out_overflowed        (out_overflowed)
  );

  // The clock runs with an 8 ns period.
  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // Rounded quotient n / (2*d), with halves going away from zero.
  function automatic wide_t half_quotient(input wide_t n, input wide_t d);
    wide_t an, ad, mag;
    an  = (n < 0) ? -n : n;
    ad  = (d < 0) ? -d : d;
    mag = (an + ad) / (ad + ad);
    return ((n < 0) != (d < 0)) ? -mag : mag;
  endfunction

  // Clamp to a signed range of the given width and note when a clamp happened.
  function automatic wide_t clamp_signed(input wide_t v, input int w, inout bit clamped);
    wide_t hi, lo;
    hi = (wide_t'(1) <<< (w - 1)) - 1;
    lo = -(wide_t'(1) <<< (w - 1));
    if (v > hi) begin
      clamped = 1;
      return hi;
    end
    if (v < lo) begin
      clamped = 1;
      return lo;
    end
    return v;
  endfunction

  // Works out center, radius and equation constant exactly, then rounds as the
  // hardware does: the offset to nearest, the radius to nearest, and the
  // constant with halves going up.
  function automatic circle_t solve_circle(input triangle_t t);
    wide_t   ax, ay, ebx, eby, ecx, ecy, cr, nb, nc, nx, ny, ox, oy, px, py;
    wide_t   lim, rad, sq, root, trial, k;
    bit      clamped;
    circle_t res;
    clamped = 0;
    ax  = t.ax;
    ay  = t.ay;
    ebx = wide_t'(t.bx) - ax;
    eby = wide_t'(t.by) - ay;
    ecx = wide_t'(t.cx) - ax;
    ecy = wide_t'(t.cy) - ay;
    cr  = ebx * ecy - eby * ecx;
    res = '{default: '0};
    if (cr == 0) begin
      res.degen = 1'b1;
      return res;
    end
    nb = ebx * ebx + eby * eby;
    nc = ecx * ecx + ecy * ecy;
    nx = ebx * nc - ecx * nb;
    ny = eby * nc - ecy * nb;
    ox = half_quotient(-ny, cr);
    oy = half_quotient(nx, cr);
    px = clamp_signed(ax + ox, CW, clamped);
    py = clamp_signed(ay + oy, CW, clamped);
    lim = wide_t'(1) <<< (CW - 1);
    rad = lim - 1;
    if (ox >= lim || -ox >= lim || oy >= lim || -oy >= lim) begin
      clamped = 1;
    end else begin
      sq   = ox * ox + oy * oy;
      root = 0;
      for (int b = CW + 2; b >= 0; b--) begin
        trial = root | (wide_t'(1) <<< b);
        if (trial * trial <= sq) root = trial;
      end
      if (sq - root * root > root) root = root + 1;
      if (root > rad) clamped = 1;
      else rad = root;
    end
    k = px * px + py * py - rad * rad + (wide_t'(1) <<< (FB - 1));
    k = k >>> FB;
    k = clamp_signed(k, EW, clamped);
    res.px  = px[CW-1:0];
    res.py  = py[CW-1:0];
    res.rad = rad[CW-2:0];
    res.k   = k[EW-1:0];
    res.ovf = clamped;
    return res;
  endfunction

  // Sends one triangle request and records what it must produce once accepted.
  // Valid stays high between back-to-back requests and only drops during a gap.
  task automatic send_triangle(input triangle_t t);
    while (!steady_mode && $urandom_range(99) < 15) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_first_x  <= t.ax;
    in_first_y  <= t.ay;
    in_second_x <= t.bx;
    in_second_y <= t.by;
    in_third_x  <= t.cx;
    in_third_y  <= t.cy;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_circles.push_back(solve_circle(t));
  endtask

  task automatic send_points(input int ax, input int ay, input int bx, input int by,
                             input int cx, input int cy);
    triangle_t t;
    t = '{ax, ay, bx, by, cx, cy};
    send_triangle(t);
  endtask

  // Holds the sender back until every outstanding result has come out.
  task automatic wait_for_drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_circles.size() != 0) @(posedge clk);
  endtask

  function automatic int small_coord();
    return int'($urandom_range(32'h0020_0000)) - 32'sh0010_0000;
  endfunction

  // Corner and range extremes, including results that must saturate.
  task automatic test_extremes();
    int mx, mn;
    mx = 32'sh7fff_ffff;
    mn = 32'sh8000_0000;
    send_points(0, 0, 32'h0001_0000, 0, 0, 32'h0001_0000);
    send_points(32'h0003_0000, 32'h0001_0000, -32'sh0002_0000, 32'h0005_0000,
                32'h0000_8000, -32'sh0004_0000);
    send_points(mn, mn, mx, mn, mn, mx);
    send_points(mx, mx, mn, mx, mx, mn);
    send_points(mn, mx, mx, mn, mx, mx);
    send_points(mn, mn, mx, mx, mx, mn);
    // Nearly collinear: thin triangles; for the second one the center lands far outside the coordinate range.
    send_points(0, 0, mx, 0, mx, 1);
    send_points(mn, 0, mx, 1, 0, 0);
    send_points(1, 0, 0, 1, -1, 0);
    send_points(-1, -1, 1, -1, -1, 1);
    send_points(0, 0, mx, mx, mn, mx);
    send_points(mx, 0, mn, 0, 0, mx);
  endtask

  // Collinear and coincident vertices give the degenerate result.
  task automatic test_degenerate();
    send_points(0, 0, 0, 0, 0, 0);
    send_points(32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000,
                32'sh7fff_ffff, 32'sh8000_0000);
    send_points(5, 7, 5, 7, 100, -3);
    send_points(0, 0, 32'h0001_0000, 32'h0001_0000, 32'h0002_0000, 32'h0002_0000);
    send_points(32'sh8000_0000, 0, 0, 0, 32'sh7fff_ffff, 0);
    send_points(3, 32'sh8000_0000, 3, 0, 3, 32'sh7fff_ffff);
  endtask

  // Triangles with moderate coordinates, where most results stay in range.
  task automatic test_random_small(input int count);
    for (int i = 0; i < count; i++) begin
      send_points(small_coord(), small_coord(), small_coord(), small_coord(),
                  small_coord(), small_coord());
    end
  endtask

  // Any 32-bit coordinates; every input bit toggles and overflow is common.
  task automatic test_random_full(input int count);
    triangle_t t;
    for (int i = 0; i < count; i++) begin
      t = '{$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      send_triangle(t);
    end
  endtask

  // Random collinear triples plus triangles one unit away from collinear.
  task automatic test_random_collinear(input int count);
    int ax, ay, dx, dy, k1, k2;
    for (int i = 0; i < count; i++) begin
      ax = small_coord();
      ay = small_coord();
      dx = int'($urandom_range(2000)) - 1000;
      dy = int'($urandom_range(2000)) - 1000;
      k1 = int'($urandom_range(200)) - 100;
      k2 = int'($urandom_range(200)) - 100;
      if ($urandom_range(1)) send_points(ax, ay, ax + k1 * dx, ay + k1 * dy,
                                         ax + k2 * dx, ay + k2 * dy);
      else send_points(ax, ay, ax + k1 * dx, ay + k1 * dy,
                       ax + k2 * dx + 1, ay + k2 * dy);
    end
  endtask

  // The receiver stalls at random except while the steady stretch runs.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= !steady_mode && ($urandom_range(99) < 15);
    end
  end

  // Every accepted result is compared with the oldest expected one.
  always @(posedge clk) begin
    circle_t exp_c;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_circles.size() == 0) begin
        mismatch_count++;
        $display("%0t: expected no result, actual cx=%0d cy=%0d", $time,
                 out_center_x, out_center_y);
      end else begin
        exp_c = pending_circles.pop_front();
        if (out_center_x !== exp_c.px || out_center_y !== exp_c.py ||
            out_radius !== exp_c.rad || out_equation_constant !== exp_c.k ||
            out_degenerate !== exp_c.degen || out_overflowed !== exp_c.ovf) begin
          mismatch_count++;
          $display("%0t: expected cx=%0d cy=%0d r=%0d k=%0d deg=%0b ovf=%0b", $time,
                   exp_c.px, exp_c.py, exp_c.rad, exp_c.k, exp_c.degen, exp_c.ovf);
          $display("%0t: actual   cx=%0d cy=%0d r=%0d k=%0d deg=%0b ovf=%0b", $time,
                   out_center_x, out_center_y, out_radius, out_equation_constant,
                   out_degenerate, out_overflowed);
        end
      end
    end
  end

  initial begin
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_first_x  = '0;
    in_first_y  = '0;
    in_second_x = '0;
    in_second_y = '0;
    in_third_x  = '0;
    in_third_y  = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_extremes();
    test_degenerate();
    // The pipeline must drain fully and then restart cleanly.
    wait_for_drain();
    // A stretch with both sides streaming at full rate.
    steady_mode = 1'b1;
    test_random_small(150);
    steady_mode = 1'b0;
    test_random_small(150);
    test_random_full(200);
    test_random_collinear(100);

    wait_for_drain();
    repeat (DrainCycles) @(posedge clk);
    if (mismatch_count == 0 && pending_circles.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Far beyond the slowest correct run: about 620 requests with random gaps and stalls.
  initial begin
    #5ms;
    $display("Some tests failed");
    $finish;
  end

endmodule
`default_nettype wire

@@ triangle_circumcircle_unit.f @@
hdl/tcc_pkg.sv
hdl/tcc_div_pipe.sv
hdl/tcc_sqrt_pipe.sv
hdl/triangle_circumcircle_unit.sv
tb/sv/tb_triangle_circumcircle_unit.sv
